>>> hw/rtl/clsr_pkg.sv
// Shared constants, types and engine interface structs for the combined LCG shuffle generator.
package clsr_pkg;

	// Table depth default and extra warm-up count added to the table depth
	localparam int unsigned TABLE_DEPTH_DEF = 32;
	localparam int unsigned WARMUP_EXTRA    = 7;

	// Reciprocal scaling for division by a constant
	localparam int unsigned RECIP_SHIFT = 46;
	localparam int unsigned PROD_W      = 63;
	localparam int unsigned QUO_W       = PROD_W - RECIP_SHIFT;

	// First generator: modulus, multiplier, Schrage quotient and remainder
	localparam logic [31:0] MOD1 = 32'd2147483563;
	localparam logic [30:0] MUL1 = 31'd40014;
	localparam logic [31:0] QUO1 = 32'd53668;
	localparam logic [31:0] REM1 = 32'd12211;

	// Second generator
	localparam logic [31:0] MOD2 = 32'd2147483399;
	localparam logic [30:0] MUL2 = 31'd40692;
	localparam logic [31:0] QUO2 = 32'd52774;
	localparam logic [31:0] REM2 = 32'd3791;

	// Output range span and second generator reset value
	localparam logic [30:0] SPAN         = 31'(MOD1 - 32'd1);
	localparam logic [30:0] SECOND_RESET = 31'd123456789;

	// Reciprocals of the Schrage quotients
	localparam logic [31:0] RECIP1 = 32'((64'd1 << RECIP_SHIFT) / {32'd0, QUO1});
	localparam logic [31:0] RECIP2 = 32'((64'd1 << RECIP_SHIFT) / {32'd0, QUO2});

	// Engine operations
	typedef enum logic [1:0] {
		OP_GEN1,
		OP_GEN2,
		OP_SLOT
	} eng_op_t;

	// Request to the arithmetic engine
	typedef struct packed {
		logic        start;
		eng_op_t     op;
		logic [30:0] x;
	} eng_req_t;

	// Response from the arithmetic engine
	typedef struct packed {
		logic             idle;
		logic             done;
		logic [QUO_W-1:0] quo;
		logic [30:0]      res;
	} eng_rsp_t;

endpackage

>>> hw/rtl/clsr_engine.sv
// Shared multiplier engine: Schrage step of either generator, or slot index division.
module clsr_engine #(
	parameter int unsigned TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  clsr_pkg::eng_req_t req,
	output clsr_pkg::eng_rsp_t rsp
);
	import clsr_pkg::*;

	// Slot divisor and its reciprocal follow the table depth
	localparam logic [63:0] SLOT_DIV    = 64'(1) + 64'(SPAN) / 64'(TABLE_DEPTH);
	localparam logic [31:0] RECIP_SLOT  = 32'((64'd1 << RECIP_SHIFT) / SLOT_DIV);
	localparam logic [31:0] SLOT_DIV_32 = 32'(SLOT_DIV);

	typedef enum logic [2:0] {
		E_IDLE,
		E_RECIP,
		E_KQ,
		E_FIX,
		E_MA,
		E_MB,
		E_SUB,
		E_DONE
	} eng_state_t;

	eng_state_t        state_q;
	eng_op_t           op_q;
	logic [30:0]       x_q;
	logic [PROD_W-1:0] prod_q;
	logic [QUO_W-1:0]  k_q;
	logic [31:0]       rem_q;
	logic [31:0]       acc_q;
	logic [30:0]       res_q;

	// Per-operation constants
	logic [31:0] c_recip;
	logic [31:0] c_div;
	logic [30:0] c_mul;
	logic [31:0] c_rem;
	logic [31:0] c_mod;

	always_comb begin
		unique case (op_q)
			OP_GEN2: begin
				c_recip = RECIP2;
				c_div   = QUO2;
				c_mul   = MUL2;
				c_rem   = REM2;
				c_mod   = MOD2;
			end
			OP_SLOT: begin
				c_recip = RECIP_SLOT;
				c_div   = SLOT_DIV_32;
				c_mul   = MUL1;
				c_rem   = REM1;
				c_mod   = MOD1;
			end
			default: begin
				c_recip = RECIP1;
				c_div   = QUO1;
				c_mul   = MUL1;
				c_rem   = REM1;
				c_mod   = MOD1;
			end
		endcase
	end

	// Estimated quotient from the reciprocal product
	logic [QUO_W-1:0] k0;
	assign k0 = prod_q[PROD_W-1:RECIP_SHIFT];

	// Shared multiplier operand select
	logic [30:0] mult_a;
	logic [31:0] mult_b;

	always_comb begin
		unique case (state_q)
			E_RECIP: begin
				mult_a = x_q;
				mult_b = c_recip;
			end
			E_KQ: begin
				mult_a = 31'(k0);
				mult_b = c_div;
			end
			E_MA: begin
				mult_a = c_mul;
				mult_b = rem_q;
			end
			E_MB: begin
				mult_a = 31'(k_q);
				mult_b = c_rem;
			end
			default: begin
				mult_a = x_q;
				mult_b = c_recip;
			end
		endcase
	end

	logic [PROD_W-1:0] prod_d;
	assign prod_d = PROD_W'(mult_a) * PROD_W'(mult_b);

	// Remainder correction: estimate is low by at most one
	logic [31:0] rem0;
	logic        rem_over;
	assign rem0     = {1'b0, x_q} - prod_q[31:0];
	assign rem_over = (rem0 >= c_div);

	// Final Schrage difference, folded by the modulus when negative
	logic [32:0] diff;
	logic [30:0] res_d;
	assign diff  = {1'b0, acc_q} - {1'b0, prod_q[31:0]};
	assign res_d = diff[32] ? (diff[30:0] + c_mod[30:0]) : diff[30:0];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			op_q    <= OP_GEN1;
		end else begin
			unique case (state_q)
				E_IDLE: begin
					if (req.start) begin
						op_q    <= req.op;
						state_q <= E_RECIP;
					end
				end
				E_RECIP: state_q <= E_KQ;
				E_KQ:    state_q <= E_FIX;
				E_FIX:   state_q <= (op_q == OP_SLOT) ? E_DONE : E_MA;
				E_MA:    state_q <= E_MB;
				E_MB:    state_q <= E_SUB;
				E_SUB:   state_q <= E_DONE;
				E_DONE:  state_q <= E_IDLE;
				default: state_q <= E_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && req.start) begin
			x_q <= req.x;
		end
		if (state_q == E_RECIP || state_q == E_KQ || state_q == E_MA || state_q == E_MB) begin
			prod_q <= prod_d;
		end
		if (state_q == E_KQ) begin
			k_q <= k0;
		end
		if (state_q == E_FIX) begin
			if (rem_over) begin
				k_q   <= k_q + QUO_W'(1);
				rem_q <= rem0 - c_div;
			end else begin
				rem_q <= rem0;
			end
		end
		if (state_q == E_MB) begin
			acc_q <= prod_q[31:0];
		end
		if (state_q == E_SUB) begin
			res_q <= res_d;
		end
	end

	assign rsp.idle = (state_q == E_IDLE);
	assign rsp.done = (state_q == E_DONE);
	assign rsp.quo  = k_q;
	assign rsp.res  = res_q;

endmodule

>>> hw/rtl/combined_lcg_shuffle_random.sv
// Top level: combined two-generator random source with a shuffle table.
//
//  channel | direction | tdata                      | tuser          | notes
//  s_*     | in        | [30:0] seed                | [0] kind       | kind 1 reseeds first
//  m_*     | out       | [30:0] value               | -              | 1 .. 2147483562
//
// Schrage steps of both generators and the slot division share one multiplier; the slot
// division ends after the remainder fix. A draw runs a step of each generator, the slot
// division, a table read and the merge, the value registered at the merge; a reseed adds (TABLE_DEPTH + 8) steps.
// Reset loads the first generator with 1, the second with 123456789, clears last output
// and marks every table entry as zero through per-entry valid bits.
// The input is taken only between items; a finished value waits in the output register
// and the next item may start while it waits.
module combined_lcg_shuffle_random #(
	parameter int unsigned TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] seed, [31] zero
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [30:0] value, [31] zero
);
	import clsr_pkg::*;

	localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
	localparam int unsigned WARM_N  = TABLE_DEPTH + WARMUP_EXTRA;
	localparam int unsigned CNT_W   = $clog2(WARM_N + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WARM,
		ST_GEN1,
		ST_GEN2,
		ST_SLOT,
		ST_READ,
		ST_MERGE
	} top_state_t;

	top_state_t       state_q;
	logic [30:0]      gen1_q;
	logic [30:0]      gen2_q;
	logic [30:0]      last_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] slot_q;
	logic             out_valid_q;
	logic [30:0]      out_data_q;
	logic             rd_vld_q;
	logic [30:0]      rd_data_q;
	logic [TABLE_DEPTH-1:0] vld_q;
	logic [30:0]      mem_q [TABLE_DEPTH];

	eng_req_t eng_req;
	eng_rsp_t eng_rsp;

	clsr_engine #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (eng_req),
		.rsp   (eng_rsp)
	);

	// Engine request by state
	always_comb begin
		eng_req.start = 1'b0;
		eng_req.op    = OP_GEN1;
		eng_req.x     = gen1_q;
		unique case (state_q)
			ST_WARM, ST_GEN1: begin
				eng_req.start = eng_rsp.idle;
			end
			ST_GEN2: begin
				eng_req.start = eng_rsp.idle;
				eng_req.op    = OP_GEN2;
				eng_req.x     = gen2_q;
			end
			ST_SLOT: begin
				eng_req.start = eng_rsp.idle;
				eng_req.op    = OP_SLOT;
				eng_req.x     = last_q;
			end
			default: ;
		endcase
	end

	// Input transaction and seed clamp
	logic        in_take;
	logic [30:0] seed_c;
	assign s_tready = (state_q == ST_IDLE);
	assign in_take  = s_tvalid && s_tready;
	assign seed_c   = (s_tdata[30:0] == 31'd0) ? 31'd1 : s_tdata[30:0];

	// Slot index from the division, saturated to the last entry
	logic [IDX_W-1:0] slot_d;
	assign slot_d = (eng_rsp.quo >= QUO_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1)
	                                                     : eng_rsp.quo[IDX_W-1:0];

	// New output: table entry minus second generator, folded into range
	logic [30:0] tbl_val;
	logic [31:0] sub_d;
	logic [30:0] last_d;
	assign tbl_val = rd_vld_q ? rd_data_q : 31'd0;
	assign sub_d   = {1'b0, tbl_val} - {1'b0, gen2_q};
	assign last_d  = ($signed(sub_d) < 32'sd1) ? (sub_d[30:0] + SPAN) : sub_d[30:0];

	// Output register free or draining this cycle
	logic commit;
	assign commit = (state_q == ST_MERGE) && (!out_valid_q || m_tready);

	// Table write port
	logic             warm_wr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [30:0]      wr_data;
	assign warm_wr = (state_q == ST_WARM) && eng_rsp.done && (cnt_q < CNT_W'(TABLE_DEPTH));
	assign wr_en   = warm_wr || commit;
	assign wr_idx  = commit ? slot_q : cnt_q[IDX_W-1:0];
	assign wr_data = commit ? gen1_q : eng_rsp.res;

	// Control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gen1_q      <= 31'd1;
			gen2_q      <= SECOND_RESET;
			last_q      <= 31'd0;
			cnt_q       <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
			rd_vld_q    <= 1'b0;
			vld_q       <= '0;
		end else begin
			// Output valid: set on commit, cleared when drained
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (s_tuser) begin
							gen1_q  <= seed_c;
							gen2_q  <= seed_c;
							cnt_q   <= CNT_W'(WARM_N);
							state_q <= ST_WARM;
						end else begin
							state_q <= ST_GEN1;
						end
					end
				end
				ST_WARM: begin
					if (eng_rsp.done) begin
						gen1_q <= eng_rsp.res;
						if (cnt_q == '0) begin
							last_q  <= eng_rsp.res;
							state_q <= ST_GEN1;
						end else begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
					end
				end
				ST_GEN1: begin
					if (eng_rsp.done) begin
						gen1_q  <= eng_rsp.res;
						state_q <= ST_GEN2;
					end
				end
				ST_GEN2: begin
					if (eng_rsp.done) begin
						gen2_q  <= eng_rsp.res;
						state_q <= ST_SLOT;
					end
				end
				ST_SLOT: begin
					if (eng_rsp.done) begin
						slot_q  <= slot_d;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					rd_vld_q <= vld_q[slot_q];
					state_q  <= ST_MERGE;
				end
				ST_MERGE: begin
					if (commit) begin
						last_q  <= last_d;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Shuffle table memory and output data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		if (state_q == ST_READ) begin
			rd_data_q <= mem_q[slot_q];
		end
		if (commit) begin
			out_data_q <= last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_data_q};

endmodule
